// ----- rtl/core/reorder_buffer_cumulative_ack_macros.svh -----
// assertion helpers used by the checker file
`ifndef REORDER_BUFFER_CUMULATIVE_ACK_MACROS_SVH
`define REORDER_BUFFER_CUMULATIVE_ACK_MACROS_SVH

// generic clocked assertion with asynchronous active-low reset
`define RBCA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define RBCA_ASSERT(lbl, prop, msg) \
  `RBCA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/rbca_pkg.sv -----
package rbca_pkg;

  localparam int unsigned BufferDepth = 16;
  localparam logic [10:0] MaxPayload  = 11'd1024;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindFin  = 2'd1;

  localparam logic [1:0] OutDeliver = 2'd0;
  localparam logic [1:0] OutAck     = 2'd1;
  localparam logic [1:0] OutFinack  = 2'd2;

  typedef struct packed {
    logic [30:0] seq;
    logic [10:0] length;
    logic [15:0] handle;
  } slot_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [30:0] key;
    logic        wr_en;
    logic        clr_en;
    slot_t       wr_data;
  } cell_ctl_t;

  // passed from each cell to its right neighbor
  typedef struct packed {
    logic  taken;
    logic  hit;
    slot_t data;
  } cell_chain_t;

endpackage

// ----- rtl/core/rbca_cell.sv -----
module rbca_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rbca_pkg::cell_ctl_t  ctl_i,
  input  rbca_pkg::cell_chain_t chain_i,
  output rbca_pkg::cell_chain_t chain_o
);

  logic            valid_q, valid_d;
  rbca_pkg::slot_t slot_q, slot_d;
  logic            hit;
  logic            wr_here;

  assign hit     = valid_q && (slot_q.seq == ctl_i.key);
  // first free cell along the row claims the write
  assign wr_here = ctl_i.wr_en && !valid_q && !chain_i.taken;

  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    if (wr_here) begin
      valid_d = 1'b1;
      slot_d  = ctl_i.wr_data;
    end else if (ctl_i.clr_en && hit) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    chain_o.taken = chain_i.taken | !valid_q;
    chain_o.hit   = chain_i.hit | hit;
    chain_o.data  = chain_i.data | (hit ? slot_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// ----- rtl/core/rbca_slot_row.sv -----
module rbca_slot_row (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbca_pkg::cell_ctl_t ctl_i,
  output logic                hit_o,
  output logic                full_o,
  output rbca_pkg::slot_t     hit_data_o
);

  rbca_pkg::cell_chain_t chain [rbca_pkg::BufferDepth+1];

  assign chain[0] = '0;

  for (genvar g = 0; g < rbca_pkg::BufferDepth; g++) begin : g_cell
    rbca_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  assign hit_o      = chain[rbca_pkg::BufferDepth].hit;
  assign full_o     = !chain[rbca_pkg::BufferDepth].taken;
  assign hit_data_o = chain[rbca_pkg::BufferDepth].data;

endmodule

// ----- rtl/core/reorder_buffer_cumulative_ack.sv -----
// latency: a FIN result strobes in the cycle after the item is taken; kinds other than FIN and data give none
// data item: the first result is registered out of the check state (out of the ack state when stale or early),
// and busy is high through the check, drain and ack states when in order, check and ack when stale or early
// the ack (last) strobes in the first cycle busy is low, where the next item can be taken
// a new item is taken only in the idle state, so it never overlaps the one before it
// reset: ack number -1, all slots empty, fin flag clear; receiver cannot stall
module reorder_buffer_cumulative_ack (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [30:0] seq_i,
  input  logic [10:0] length_i,
  input  logic [15:0] handle_i,
  output logic        strobe,
  output logic [1:0]  out_kind_o,
  output logic [31:0] out_number_o,
  output logic [10:0] out_length_o,
  output logic [15:0] out_handle_o,
  output logic        dropped_o,
  output logic        last_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StAck   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [31:0]         acked_q, acked_d;
  logic                fin_q, fin_d;
  logic                drop_q, drop_d;
  rbca_pkg::slot_t     item_q, item_d;

  logic                strobe_q, strobe_d;
  logic [1:0]          okind_q, okind_d;
  logic [31:0]         onum_q, onum_d;
  logic [10:0]         olen_q, olen_d;
  logic [15:0]         ohandle_q, ohandle_d;
  logic                odrop_q, odrop_d;
  logic                olast_q, olast_d;

  rbca_pkg::cell_ctl_t ctl;
  logic                row_hit, row_full;
  rbca_pkg::slot_t     row_data;

  logic signed [32:0]  next_ext, seq_ext;
  logic                in_order, early, at_top;
  logic [10:0]         len_sat;

  assign next_ext = $signed({acked_q[31], acked_q}) + 33'sd1;
  assign seq_ext  = $signed({2'b00, item_q.seq});
  assign in_order = (seq_ext == next_ext);
  assign early    = (seq_ext > next_ext);
  // nothing can follow the top of the sequence space
  assign at_top   = (acked_q == 32'h7FFF_FFFF);
  assign len_sat  = (length_i > rbca_pkg::MaxPayload) ? rbca_pkg::MaxPayload : length_i;

  always_comb begin
    ctl.key     = (state_q == StDrain) ? (acked_q[30:0] + 31'd1) : item_q.seq;
    ctl.wr_en   = (state_q == StCheck) && early && !row_hit;
    ctl.clr_en  = (state_q == StDrain) && !at_top;
    ctl.wr_data = item_q;
  end

  rbca_slot_row u_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .hit_o      (row_hit),
    .full_o     (row_full),
    .hit_data_o (row_data)
  );

  always_comb begin
    state_d   = state_q;
    acked_d   = acked_q;
    fin_d     = fin_q;
    drop_d    = drop_q;
    item_d    = item_q;
    strobe_d  = 1'b0;
    okind_d   = okind_q;
    onum_d    = onum_q;
    olen_d    = olen_q;
    ohandle_d = ohandle_q;
    odrop_d   = odrop_q;
    olast_d   = olast_q;

    unique case (state_q)
      StIdle: begin
        if (start && !fin_q) begin
          if (kind_i == rbca_pkg::KindFin) begin
            fin_d     = 1'b1;
            strobe_d  = 1'b1;
            okind_d   = rbca_pkg::OutFinack;
            onum_d    = '0;
            olen_d    = '0;
            ohandle_d = '0;
            odrop_d   = 1'b0;
            olast_d   = 1'b1;
          end else if (kind_i == rbca_pkg::KindData) begin
            item_d.seq    = seq_i;
            item_d.length = len_sat;
            item_d.handle = handle_i;
            drop_d        = 1'b0;
            state_d       = StCheck;
          end
        end
      end
      StCheck: begin
        if (in_order) begin
          strobe_d  = 1'b1;
          okind_d   = rbca_pkg::OutDeliver;
          onum_d    = {1'b0, item_q.seq};
          olen_d    = item_q.length;
          ohandle_d = item_q.handle;
          odrop_d   = 1'b0;
          olast_d   = 1'b0;
          acked_d   = {1'b0, item_q.seq};
          state_d   = StDrain;
        end else begin
          // early packet with no duplicate and no free cell is discarded
          if (early && !row_hit && row_full) begin
            drop_d = 1'b1;
          end
          state_d = StAck;
        end
      end
      StDrain: begin
        if (row_hit && !at_top) begin
          strobe_d  = 1'b1;
          okind_d   = rbca_pkg::OutDeliver;
          onum_d    = {1'b0, row_data.seq};
          olen_d    = row_data.length;
          ohandle_d = row_data.handle;
          odrop_d   = 1'b0;
          olast_d   = 1'b0;
          acked_d   = {1'b0, row_data.seq};
        end else begin
          state_d = StAck;
        end
      end
      StAck: begin
        strobe_d  = 1'b1;
        okind_d   = rbca_pkg::OutAck;
        onum_d    = acked_q;
        olen_d    = '0;
        ohandle_d = '0;
        odrop_d   = drop_q;
        olast_d   = 1'b1;
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      acked_q  <= '1;
      fin_q    <= 1'b0;
      drop_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acked_q  <= acked_d;
      fin_q    <= fin_d;
      drop_q   <= drop_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    okind_q   <= okind_d;
    onum_q    <= onum_d;
    olen_q    <= olen_d;
    ohandle_q <= ohandle_d;
    odrop_q   <= odrop_d;
    olast_q   <= olast_d;
  end

  assign busy         = (state_q != StIdle);
  assign strobe       = strobe_q;
  assign out_kind_o   = okind_q;
  assign out_number_o = onum_q;
  assign out_length_o = olen_q;
  assign out_handle_o = ohandle_q;
  assign dropped_o    = odrop_q;
  assign last_o       = olast_q;

endmodule

// ----- rtl/core/rbca_checker.sv -----
`include "reorder_buffer_cumulative_ack_macros.svh"

module rbca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        strobe,
  input logic [1:0]  out_kind_o,
  input logic [31:0] out_number_o,
  input logic        dropped_o,
  input logic        last_o
);

  // a fin ack is a lone final result with number zero
  `RBCA_ASSERT(a_finack_last, strobe && out_kind_o == rbca_pkg::OutFinack |-> last_o && out_number_o == 32'd0, "finack malformed")
  // deliveries are never the final result and never flag a drop
  `RBCA_ASSERT(a_deliver_not_last, strobe && out_kind_o == rbca_pkg::OutDeliver |-> !last_o && !dropped_o, "delivery marked last or dropped")
  // an ack still has to follow a delivery, so the block stays busy
  `RBCA_ASSERT(a_deliver_busy, strobe && out_kind_o == rbca_pkg::OutDeliver |-> busy, "idle after delivery")
  // after fin the block goes silent
  `RBCA_ASSERT(a_finack_silent, strobe && out_kind_o == rbca_pkg::OutFinack |=> !strobe, "result after finack")

endmodule

bind reorder_buffer_cumulative_ack rbca_checker u_rbca_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy         (busy),
  .strobe       (strobe),
  .out_kind_o   (out_kind_o),
  .out_number_o (out_number_o),
  .dropped_o    (dropped_o),
  .last_o       (last_o)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  // kinds the block ignores
  localparam logic [1:0] KindOther = 2'd2;
  localparam logic [1:0] KindResv  = 2'd3;

  localparam int DirRowCount  = 24;
  localparam int RandomItems  = 100;
  localparam int DrainCycles  = 30;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] number;
    logic [10:0] length;
    logic [15:0] handle;
    logic        dropped;
    logic        last;
  } rx_result_t;

  // one descriptor; typed rows carry their single ack result inline
  typedef struct {
    logic [1:0]  kind;
    logic [30:0] seq;
    logic [10:0] length;
    logic [15:0] handle;
    bit          typed;
    logic [31:0] ack_number;
    logic        dropped;
  } packet_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind_i = rbca_pkg::KindData;
  logic [30:0] seq_i = '0;
  logic [10:0] length_i = '0;
  logic [15:0] handle_i = '0;
  logic        strobe;
  logic [1:0]  out_kind_o;
  logic [31:0] out_number_o;
  logic [10:0] out_length_o;
  logic [15:0] out_handle_o;
  logic        dropped_o;
  logic        last_o;

  reorder_buffer_cumulative_ack DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .seq_i        (seq_i),
    .length_i     (length_i),
    .handle_i     (handle_i),
    .strobe       (strobe),
    .out_kind_o   (out_kind_o),
    .out_number_o (out_number_o),
    .out_length_o (out_length_o),
    .out_handle_o (out_handle_o),
    .dropped_o    (dropped_o),
    .last_o       (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver-side copy of the reorder state
  logic signed [31:0] ack_seq;
  logic               held_valid [rbca_pkg::BufferDepth];
  logic [30:0]        held_seq [rbca_pkg::BufferDepth];
  logic [10:0]        held_length [rbca_pkg::BufferDepth];
  logic [15:0]        held_handle [rbca_pkg::BufferDepth];
  logic               fin_seen;

  rx_result_t   expected_results[$];
  rx_result_t   packet_results[$];
  packet_row_t  dir_rows [DirRowCount];
  int           mismatches = 0;
  int           sender_idle_pct = 0;

  function automatic void predict_packet(input logic [1:0] kind, input logic [30:0] seq,
                                         input logic [10:0] len, input logic [15:0] hdl);
    logic [10:0]        clen;
    logic signed [32:0] next_seq;
    logic signed [32:0] seq_ext;
    logic               found;
    logic               dup;
    logic               drop;
    int                 free_idx;
    packet_results.delete();
    if (fin_seen) return;
    if (kind == rbca_pkg::KindFin) begin
      fin_seen = 1'b1;
      packet_results.push_back({rbca_pkg::OutFinack, 32'd0, 11'd0, 16'd0, 1'b0, 1'b1});
      return;
    end
    if (kind != rbca_pkg::KindData) return;
    clen = (len > rbca_pkg::MaxPayload) ? rbca_pkg::MaxPayload : len;
    drop = 1'b0;
    seq_ext = $signed({2'b00, seq});
    next_seq = {ack_seq[31], ack_seq} + 33'sd1;
    if (seq_ext == next_seq) begin
      packet_results.push_back({rbca_pkg::OutDeliver, {1'b0, seq}, clen, hdl, 1'b0, 1'b0});
      ack_seq = {1'b0, seq};
      // drain held successors in order
      do begin
        found = 1'b0;
        next_seq = {ack_seq[31], ack_seq} + 33'sd1;
        for (int i = 0; i < rbca_pkg::BufferDepth; i++) begin
          if (!found && held_valid[i] && $signed({2'b00, held_seq[i]}) == next_seq) begin
            packet_results.push_back({rbca_pkg::OutDeliver, {1'b0, held_seq[i]},
                                      held_length[i], held_handle[i], 1'b0, 1'b0});
            ack_seq = {1'b0, held_seq[i]};
            held_valid[i] = 1'b0;
            found = 1'b1;
          end
        end
      end while (found);
    end else if (seq_ext > next_seq) begin
      dup = 1'b0;
      free_idx = -1;
      for (int i = 0; i < rbca_pkg::BufferDepth; i++) begin
        if (held_valid[i]) begin
          if (held_seq[i] == seq) dup = 1'b1;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (!dup) begin
        if (free_idx >= 0) begin
          held_valid[free_idx] = 1'b1;
          held_seq[free_idx] = seq;
          held_length[free_idx] = clen;
          held_handle[free_idx] = hdl;
        end else begin
          drop = 1'b1;
        end
      end
    end
    packet_results.push_back({rbca_pkg::OutAck, ack_seq, 11'd0, 16'd0, drop, 1'b1});
  endfunction

  task automatic send_packet(input packet_row_t row);
    int gap;
    @(negedge clk_i);
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start    <= 1'b1;
    kind_i   <= row.kind;
    seq_i    <= row.seq;
    length_i <= row.length;
    handle_i <= row.handle;
    do @(posedge clk_i); while (busy);
    predict_packet(row.kind, row.seq, row.length, row.handle);
    if (row.typed) begin
      packet_results.delete();
      packet_results.push_back({rbca_pkg::OutAck, row.ack_number, 11'd0, 16'd0,
                                row.dropped, 1'b1});
    end
    foreach (packet_results[i]) expected_results.push_back(packet_results[i]);
  endtask

  // mostly in-window traffic so that buffering and drains happen
  task automatic send_random_packet(output bit counted);
    packet_row_t        row;
    int                 pick;
    logic signed [32:0] next_seq;
    logic [30:0]        held[$];
    pick = $urandom_range(0, 99);
    next_seq = {ack_seq[31], ack_seq} + 33'sd1;
    row.kind = rbca_pkg::KindData;
    row.typed = 1'b0;
    row.ack_number = '0;
    row.dropped = 1'b0;
    row.seq = next_seq[30:0];
    row.length = ($urandom_range(0, 99) < 15) ? 11'($urandom_range(1025, 2047))
                                               : 11'($urandom_range(0, 1024));
    row.handle = 16'($urandom_range(0, 65535));
    counted = 1'b1;
    if (pick < 45) begin
      row.seq = next_seq[30:0];
    end else if (pick < 78) begin
      row.seq = next_seq[30:0] + 31'($urandom_range(1, 24));
    end else if (pick < 86) begin
      if (!ack_seq[31]) row.seq = 31'($urandom_range(0, ack_seq));
    end else if (pick < 90) begin
      for (int i = 0; i < rbca_pkg::BufferDepth; i++)
        if (held_valid[i]) held.push_back(held_seq[i]);
      if (held.size() > 0) row.seq = held[$urandom_range(0, held.size() - 1)];
      else row.seq = next_seq[30:0] + 31'd2;
    end else if (pick < 93) begin
      row.seq = 31'($urandom);
    end else begin
      row.kind = pick[0] ? KindOther : KindResv;
      row.seq = 31'($urandom);
      counted = 1'b0;
    end
    send_packet(row);
  endtask

  always @(posedge clk_i) begin
    rx_result_t got;
    rx_result_t want;
    if (rst_ni && strobe) begin
      got = {out_kind_o, out_number_o, out_length_o, out_handle_o, dropped_o, last_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d number %0d length %0d handle %h drop %b last %b",
                 $time, got.kind, $signed(got.number), got.length, got.handle, got.dropped,
                 got.last);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: mismatch expected kind %0d number %0d length %0d handle %h drop %b last %b",
                   $time, want.kind, $signed(want.number), want.length, want.handle,
                   want.dropped, want.last);
          $display("%0t:          actual kind %0d number %0d length %0d handle %h drop %b last %b",
                   $time, got.kind, $signed(got.number), got.length, got.handle, got.dropped,
                   got.last);
        end
      end
    end
  end

  initial begin
    packet_row_t tail_row;
    bit          counted;
    int          sent;
    ack_seq = -32'sd1;
    fin_seen = 1'b0;
    foreach (held_valid[i]) held_valid[i] = 1'b0;

    dir_rows = '{
      '{KindOther,          31'd0,        11'd0,    16'h0000, 1'b0, 32'h0,        1'b0},
      '{KindResv,           31'h7FFFFFFF, 11'd2047, 16'hFFFF, 1'b0, 32'h0,        1'b0},
      '{rbca_pkg::KindData, 31'd5,        11'd1024, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
      '{rbca_pkg::KindData, 31'd5,        11'd3,    16'h0001, 1'b1, 32'hFFFFFFFF, 1'b0},
      '{rbca_pkg::KindData, 31'd0,        11'd0,    16'h0000, 1'b0, 32'h0,        1'b0},
      '{rbca_pkg::KindData, 31'd0,        11'd9,    16'h0009, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd2,        11'd1025, 16'h8000, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd3,        11'd1,    16'h0003, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd4,        11'd512,  16'h0004, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd6,        11'd18,   16'h0006, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd7,        11'd21,   16'h0007, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd8,        11'd24,   16'h0008, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd9,        11'd27,   16'h0009, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd10,       11'd30,   16'h000A, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd11,       11'd33,   16'h000B, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd12,       11'd36,   16'h000C, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd13,       11'd39,   16'h000D, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd14,       11'd42,   16'h000E, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd15,       11'd45,   16'h000F, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd16,       11'd1536, 16'h0010, 1'b1, 32'd0,        1'b0},
      '{rbca_pkg::KindData, 31'd17,       11'd51,   16'h0011, 1'b1, 32'd0,        1'b0},
      // every slot taken: this one is discarded
      '{rbca_pkg::KindData, 31'd18,       11'd100,  16'h1818, 1'b1, 32'd0,        1'b1},
      // fills the gap, drains all sixteen slots
      '{rbca_pkg::KindData, 31'd1,        11'd2047, 16'hFFFF, 1'b0, 32'h0,        1'b0},
      '{rbca_pkg::KindData, 31'h7FFFFFFF, 11'd1024, 16'h5555, 1'b1, 32'd17,       1'b0}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 20;
    foreach (dir_rows[i]) send_packet(dir_rows[i]);

    sent = 0;
    while (sent < RandomItems) begin
      sender_idle_pct = (sent < RandomItems / 3) ? 20 :
                        (sent < 2 * RandomItems / 3) ? 60 : 0;
      send_random_packet(counted);
      if (counted) sent++;
    end

    // fin, then items that must be ignored
    tail_row = '{rbca_pkg::KindFin, 31'd0, 11'd0, 16'h0000, 1'b0, 32'h0, 1'b0};
    send_packet(tail_row);
    tail_row.kind = rbca_pkg::KindData;
    tail_row.seq = ack_seq[30:0] + 31'd1;
    send_packet(tail_row);
    tail_row.kind = rbca_pkg::KindFin;
    send_packet(tail_row);
    @(negedge clk_i);
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS reorder_buffer_cumulative_ack");
    end else begin
      $display("FAIL reorder_buffer_cumulative_ack");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL reorder_buffer_cumulative_ack");
    $finish;
  end

endmodule
